>>> rtl/residue_log_distance_composition_top_defines.svh
// ----------------------------------------------------------------------------
// Residue log-distance composition: assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RESIDUE_LOG_DISTANCE_COMPOSITION_TOP_DEFINES_SVH
`define RESIDUE_LOG_DISTANCE_COMPOSITION_TOP_DEFINES_SVH

// same-cycle implication
`define RLDC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RLDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rldc_pkg.sv
// ----------------------------------------------------------------------------
// rldc_pkg
// Widths, codes and the log table builder for the log-distance composition unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rldc_pkg;

	localparam int MAX_LENGTH    = 1024;
	localparam int FRACTION_BITS = 16;
	localparam int NUM_CLASSES   = 20;

	localparam int ADDR_W   = $clog2(MAX_LENGTH);
	localparam int LEN_W    = ADDR_W + 1;
	localparam int CNT_W    = LEN_W;
	localparam int CODE_W   = 5;
	// ln(d) < log2(d) <= ADDR_W
	localparam int LN_INT_W = $clog2(ADDR_W + 1);
	localparam int LN_W     = LN_INT_W + FRACTION_BITS;
	localparam int TOT_W    = LN_W + ADDR_W;
	localparam int NUM_W    = TOT_W + LEN_W;
	localparam int COMP_W   = 17;
	localparam int WGT_W    = 24;
	localparam int DQ_W     = (LEN_W + FRACTION_BITS > WGT_W) ? LEN_W + FRACTION_BITS : WGT_W;
	localparam int STEP_W   = $clog2(DQ_W + 1);

	localparam logic [CODE_W-1:0] UNKNOWN_CODE = CODE_W'(NUM_CLASSES);
	localparam logic [CODE_W-1:0] CLS_LAST     = CODE_W'(NUM_CLASSES - 1);
	localparam logic [COMP_W-1:0] COMP_MAX     = '1;
	localparam logic [WGT_W-1:0]  WGT_MAX      = '1;
	localparam logic [63:0]       LN2_Q30      = 64'd744261118;

	// command codes (s_axis_tuser)
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [LN_W-1:0]   ln_t;
	typedef ln_t               ln_tab_t [MAX_LENGTH];

	// divider request: remainder seed, dividend bits left aligned, divisor, step count
	typedef struct packed {
		logic [NUM_W-1:0]  rem;
		logic [DQ_W-1:0]   bits;
		logic [NUM_W-1:0]  den;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	localparam logic [7:0] CLASS_LETTERS [NUM_CLASSES] = '{
		"A", "R", "N", "D", "C", "Q", "E", "G", "H", "I",
		"L", "K", "M", "F", "P", "S", "T", "W", "Y", "V"
	};

	function automatic code_t letter_class(input logic [7:0] ch);
		code_t res;
		res = UNKNOWN_CODE;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (CLASS_LETTERS[c] == ch) res = CODE_W'(c);
		end
		return res;
	endfunction

	// ln(d) by repeated squaring of the normalized mantissa, Q.30 then rounded
	function automatic ln_t ln_fixed(input int unsigned d);
		int unsigned n;
		logic [63:0] m;
		logic [63:0] lg;
		logic [63:0] prod;
		logic [63:0] rnd;
		n = 0;
		while ((d >> (n + 1)) != 0) n++;
		m  = (64'(d) << 30) >> n;
		lg = 64'(n) << 30;
		for (int k = 1; k <= 30; k++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m  = m >> 1;
				lg = lg | (64'd1 << (30 - k));
			end
		end
		prod = (lg * LN2_Q30) >> 30;
		rnd  = (prod + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
		return rnd[LN_W-1:0];
	endfunction

	function automatic ln_tab_t ln_table_build();
		ln_tab_t tab;
		for (int d = 0; d < MAX_LENGTH; d++) begin
			tab[d] = (d < 2) ? '0 : ln_fixed(d);
		end
		return tab;
	endfunction

endpackage

`default_nettype wire

>>> rtl/rldc_ln_rom.sv
// ----------------------------------------------------------------------------
// rldc_ln_rom
// ln(d) lookup ROM, one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rldc_ln_rom (
	input  wire                         clk,
	input  wire [rldc_pkg::ADDR_W-1:0]  addr,
	output logic [rldc_pkg::LN_W-1:0]   rdata
);
	import rldc_pkg::*;

	localparam ln_tab_t LN_TABLE = ln_table_build();

	always_ff @(posedge clk) begin
		rdata <= LN_TABLE[addr];
	end

endmodule

`default_nettype wire

>>> rtl/rldc_res_ram.sv
// ----------------------------------------------------------------------------
// rldc_res_ram
// Residue class store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rldc_res_ram (
	input  wire                         clk,
	input  wire                         we,
	input  wire [rldc_pkg::ADDR_W-1:0]  waddr,
	input  wire [rldc_pkg::CODE_W-1:0]  wdata,
	input  wire [rldc_pkg::ADDR_W-1:0]  raddr,
	output logic [rldc_pkg::CODE_W-1:0] rdata
);
	import rldc_pkg::*;

	code_t mem [MAX_LENGTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/rldc_div.sv
// ----------------------------------------------------------------------------
// rldc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rldc_div (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  rldc_pkg::div_req_t         req,
	output logic                       done,
	output logic [rldc_pkg::DQ_W-1:0]  quot
);
	import rldc_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [NUM_W-1:0]  rem_q;
	logic [DQ_W-1:0]   bits_q;
	logic [NUM_W-1:0]  den_q;
	logic [DQ_W-1:0]   quot_q;

	logic [NUM_W:0]    trial;
	logic              ge;
	logic [NUM_W-1:0]  nxt_rem;

	// trial subtract of the shifted remainder
	always_comb begin
		trial   = {rem_q, bits_q[DQ_W-1]};
		ge      = trial >= {1'b0, den_q};
		nxt_rem = ge ? NUM_W'(trial - {1'b0, den_q}) : NUM_W'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= req.rem;
			bits_q <= req.bits;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= nxt_rem;
			bits_q <= bits_q << 1;
			quot_q <= {quot_q[DQ_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

>>> rtl/residue_log_distance_composition_top.sv
// ----------------------------------------------------------------------------
// residue_log_distance_composition_top
// Loads a residue sequence into a class store and answers position queries
// with per-class composition and log-distance weighted composition.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                         | tuser            | tlast
//  s_axis   | in  | residue[7:0], position[17:8]  | command          | last
//  m_axis   | out | class_index, composition,     | position_invalid | last_of_run
//           |     | weighted_composition          |                  |
//
// A load is written to the store as it is accepted. A valid query scans the store
// (one residue RAM read and one ln ROM read per cycle, then a drain state), then
// steps each class through setup, composition (on a shared bit-serial divider),
// weighted ratio (on the divider) and emit; a zero or saturated weight skips the
// weighted division.
// Reset leaves the store undefined, length zero and the next load starting a
// new sequence. Output stalls hold the result register and stop the class loop.
`default_nettype none

module residue_log_distance_composition_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [23:0] s_axis_tdata,   // residue[7:0], position[17:8], zero pad
	input  wire  [0:0]  s_axis_tuser,   // command
	input  wire         s_axis_tlast,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [47:0] m_axis_tdata,   // class_index[4:0], composition[21:5],
	                                    // weighted_composition[45:22], zero pad
	output logic [0:0]  m_axis_tuser,   // position_invalid
	output logic        m_axis_tlast
);
	import rldc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_DRAIN, ST_MUL, ST_CDIV, ST_CWAIT, ST_WDIV, ST_WWAIT, ST_EMIT
	} state_t;

	state_t            state_q;
	logic [LEN_W-1:0]  len_q;
	logic              fin_q;
	logic [CNT_W-1:0]  counts_q [NUM_CLASSES];
	logic [TOT_W-1:0]  wsum_q [NUM_CLASSES];
	logic [TOT_W-1:0]  total_q;
	logic [ADDR_W-1:0] pos_q;
	logic              inv_q;
	logic [ADDR_W-1:0] j_q;
	code_t             cls_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  den_q;
	logic [COMP_W-1:0] comp_q;
	logic [WGT_W-1:0]  wgt_q;
	logic              valid_s1;
	logic              out_valid_q;
	logic [47:0]       out_data_q;
	logic              out_inv_q;
	logic              out_last_q;

	// input decode
	logic [7:0]        in_residue;
	logic [ADDR_W-1:0] in_position;
	logic              in_acc;
	logic              load_acc;
	logic              query_acc;
	assign in_residue  = s_axis_tdata[7:0];
	assign in_position = s_axis_tdata[17:8];
	assign in_acc      = s_axis_tvalid && s_axis_tready;
	assign load_acc    = in_acc && (s_axis_tuser[0] == CMD_LOAD);
	assign query_acc   = in_acc && (s_axis_tuser[0] == CMD_QUERY);
	assign s_axis_tready = (state_q == ST_IDLE);

	// load path
	logic [LEN_W-1:0]  len_base;
	logic              room;
	code_t             ld_code;
	code_t             ld_idx;
	always_comb begin
		len_base = fin_q ? '0 : len_q;
		room     = len_base < LEN_W'(MAX_LENGTH);
		ld_code  = letter_class(in_residue);
		ld_idx   = (ld_code < UNKNOWN_CODE) ? ld_code : '0;
	end

	// scan addressing
	logic [ADDR_W-1:0] ln_addr;
	code_t             code_s1;
	logic [LN_W-1:0]   ln_s1;
	assign ln_addr = (j_q > pos_q) ? (j_q - pos_q) : (pos_q - j_q);

	rldc_res_ram u_ram (
		.clk   (clk),
		.we    (load_acc && room),
		.waddr (len_base[ADDR_W-1:0]),
		.wdata (ld_code),
		.raddr (j_q),
		.rdata (code_s1)
	);

	rldc_ln_rom u_rom (
		.clk   (clk),
		.addr  (ln_addr),
		.rdata (ln_s1)
	);

	// single read port on counts and class sums
	code_t            cnt_sel;
	code_t            ws_sel;
	logic             acc_hit;
	logic [CNT_W-1:0] cnt_rd;
	logic [TOT_W-1:0] ws_rd;
	always_comb begin
		cnt_sel = (state_q == ST_IDLE) ? ld_idx : cls_q;
		acc_hit = valid_s1 && (code_s1 < UNKNOWN_CODE);
		ws_sel  = acc_hit ? code_s1 : cls_q;
		cnt_rd  = counts_q[cnt_sel];
		ws_rd   = wsum_q[ws_sel];
	end

	// divider requests
	logic [NUM_W+FRACTION_BITS-1:0] nsh;
	logic                           wzero;
	logic                           wsat;
	logic                           div_start;
	div_req_t                       div_req;
	logic                           div_done;
	logic [DQ_W-1:0]                div_quot;
	always_comb begin
		nsh   = {num_q, {FRACTION_BITS{1'b0}}};
		wzero = inv_q || (den_q == '0);
		wsat  = nsh >= {den_q, {WGT_W{1'b0}}};
		if (state_q == ST_CDIV) begin
			div_req.rem   = '0;
			div_req.bits  = DQ_W'({cnt_rd, {FRACTION_BITS{1'b0}}}) << (DQ_W - CNT_W - FRACTION_BITS);
			div_req.den   = NUM_W'(len_q);
			div_req.steps = STEP_W'(CNT_W + FRACTION_BITS);
		end else begin
			div_req.rem   = NUM_W'(nsh >> WGT_W);
			div_req.bits  = DQ_W'(nsh[WGT_W-1:0]) << (DQ_W - WGT_W);
			div_req.den   = den_q;
			div_req.steps = STEP_W'(WGT_W);
		end
		div_start = ((state_q == ST_CDIV) && (len_q != '0))
		         || ((state_q == ST_WDIV) && !wzero && !wsat);
	end

	rldc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	logic emit_go;
	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

	// sequencer, class counts, sums and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			fin_q       <= 1'b1;
			total_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			j_q         <= '0;
			cls_q       <= '0;
			inv_q       <= 1'b0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				counts_q[c] <= '0;
				wsum_q[c]   <= '0;
			end
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
			if (emit_go) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;

			// scan accumulation, one residue per cycle
			if (valid_s1) begin
				total_q <= total_q + TOT_W'(ln_s1);
				if (acc_hit) wsum_q[ws_sel] <= ws_rd + TOT_W'(ln_s1);
			end

			case (state_q)
				ST_IDLE: begin
					if (load_acc) begin
						// new sequence clears the other counts
						for (int c = 0; c < NUM_CLASSES; c++) begin
							if (room && (CODE_W'(c) == ld_idx))
								counts_q[c] <= (fin_q ? '0 : cnt_rd) + 1'b1;
							else if (fin_q)
								counts_q[c] <= '0;
						end
						len_q <= len_base + LEN_W'(room);
						fin_q <= s_axis_tlast;
					end else if (query_acc) begin
						pos_q   <= in_position;
						inv_q   <= LEN_W'(in_position) >= len_q;
						total_q <= '0;
						for (int c = 0; c < NUM_CLASSES; c++) wsum_q[c] <= '0;
						j_q     <= '0;
						cls_q   <= '0;
						state_q <= (LEN_W'(in_position) >= len_q) ? ST_MUL : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (LEN_W'(j_q) == len_q - 1'b1) state_q <= ST_DRAIN;
					else j_q <= j_q + 1'b1;
				end
				ST_DRAIN: state_q <= ST_MUL;
				ST_MUL: begin
					num_q   <= NUM_W'(ws_rd) * NUM_W'(len_q);
					den_q   <= NUM_W'(total_q) * NUM_W'(cnt_rd);
					state_q <= ST_CDIV;
				end
				ST_CDIV: begin
					if (len_q == '0) begin
						comp_q  <= '0;
						state_q <= ST_WDIV;
					end else begin
						state_q <= ST_CWAIT;
					end
				end
				ST_CWAIT: begin
					if (div_done) begin
						comp_q  <= (div_quot > DQ_W'(COMP_MAX)) ? COMP_MAX : div_quot[COMP_W-1:0];
						state_q <= ST_WDIV;
					end
				end
				ST_WDIV: begin
					if (wzero) begin
						wgt_q   <= '0;
						state_q <= ST_EMIT;
					end else if (wsat) begin
						wgt_q   <= WGT_MAX;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_WWAIT;
					end
				end
				ST_WWAIT: begin
					if (div_done) begin
						wgt_q   <= div_quot[WGT_W-1:0];
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						out_data_q  <= 48'({wgt_q, comp_q, cls_q});
						out_inv_q   <= inv_q;
						out_last_q  <= (cls_q == CLS_LAST);
						if (cls_q == CLS_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							cls_q   <= cls_q + 1'b1;
							state_q <= ST_MUL;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_inv_q;
	assign m_axis_tlast    = out_last_q;

endmodule

`default_nettype wire

>>> rtl/rldc_checker.sv
// ----------------------------------------------------------------------------
// rldc_checker
// Port-level checks on the result stream of the composition unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "residue_log_distance_composition_top_defines.svh"

module rldc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [47:0] m_axis_tdata,
	input wire [0:0]  m_axis_tuser,
	input wire        m_axis_tlast
);

	// stalled result holds
	`RLDC_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")
	// run ends on the last class
	`RLDC_ASSERT_NOW(a_last_cls, m_axis_tvalid && m_axis_tlast, m_axis_tdata[4:0] == 5'd19, "tlast not on last class")
	// class index range
	`RLDC_ASSERT_NOW(a_cls_rng, m_axis_tvalid, m_axis_tdata[4:0] < 5'd20, "class index out of range")
	// invalid position gives no weight
	`RLDC_ASSERT_NOW(a_inv_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[45:22] == 24'd0, "weight on invalid position")

endmodule

bind residue_log_distance_composition_top rldc_checker u_rldc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
